/* hw/rtl/masked_box_blur_3x3_assert.svh */
// Assertion macros shared by the masked box blur RTL.
`ifndef MASKED_BOX_BLUR_3X3_ASSERT_SVH
`define MASKED_BOX_BLUR_3X3_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the following cycle.
`define MBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mbb_pkg.sv */
// Types, constants and the divisor table of the masked 3x3 box blur.
package mbb_pkg;

  localparam int ChanW          = 16;
  localparam int SideW          = 11;
  localparam int SideReset      = 64;
  localparam int MaxSideDefault = 1024;
  localparam int RowSumW        = 18;
  localparam int SumW           = 20;
  localparam int RecipW         = 24;
  localparam int RecipShift     = 23;
  localparam int ProdW          = SumW + RecipW;
  localparam int QueueDepth     = 8;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic             keep;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             last_pixel;
  } out_item_t;

  // One stored pixel: chan[0] red, chan[1] green, chan[2] blue.
  typedef struct packed {
    logic                  keep;
    logic [2:0][ChanW-1:0] chan;
  } pixel_t;

  // One line memory word: the same column of the two previous rows.
  typedef struct packed {
    pixel_t newer;
    pixel_t older;
  } line_pair_t;

  // Control that travels with an item from acceptance to the mean unit.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [3:0] count;
    logic [8:0] tap_mask;
  } emit_ctl_t;

  // Scaled reciprocal of a neighborhood size; exact for sums below 2**21.
  function automatic logic [RecipW-1:0] recip(input logic [3:0] count);
    logic [RecipW-1:0] m;
    unique case (count)
      4'd1:    m = 24'd8388608;
      4'd2:    m = 24'd4194304;
      4'd3:    m = 24'd2796203;
      4'd4:    m = 24'd2097152;
      4'd6:    m = 24'd1398102;
      4'd9:    m = 24'd932068;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/mbb_line_window.sv */
// Line memory with read-modify-write forwarding and the 3x3 window register.
module mbb_line_window #(
  parameter int MAX_SIDE = mbb_pkg::MaxSideDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          enter,
  input  logic [$clog2(MAX_SIDE)-1:0]   enter_col,
  input  mbb_pkg::pixel_t               enter_pix,
  input  mbb_pkg::emit_ctl_t            enter_ctl,
  output mbb_pkg::pixel_t [2:0][2:0]    window,
  output mbb_pkg::emit_ctl_t            window_ctl
);

  localparam int AddrW = $clog2(MAX_SIDE);

  mbb_pkg::line_pair_t line_mem [MAX_SIDE];

  logic                 s1_valid;
  logic [AddrW-1:0]     s1_col;
  mbb_pkg::pixel_t      s1_pix;
  mbb_pkg::emit_ctl_t   s1_ctl;
  mbb_pkg::line_pair_t  rd_pair;
  mbb_pkg::line_pair_t  fwd_pair;
  logic                 fwd_hit;
  mbb_pkg::line_pair_t  cur_pair;
  mbb_pkg::line_pair_t  wr_pair;

  // The read at acceptance misses a write to the same column in that cycle.
  assign cur_pair      = fwd_hit ? fwd_pair : rd_pair;
  assign wr_pair.older = cur_pair.newer;
  assign wr_pair.newer = s1_pix;

  // Memory: read at acceptance, write back in the following cycle.
  always_ff @(posedge clk) begin
    if (enter) begin
      rd_pair <= line_mem[enter_col];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= wr_pair;
    end
  end

  // Forwarding capture for a same-column read during a write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (enter) begin
      fwd_hit <= s1_valid && (enter_col == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      fwd_pair <= wr_pair;
    end
  end

  // Stage one holds the item while its memory word comes back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_col <= enter_col;
      s1_pix <= enter_pix;
      s1_ctl <= enter_ctl;
    end
  end

  // Window shifts one column left; the new right column is two rows from
  // memory and the incoming pixel.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= cur_pair.older;
      window[1][2] <= cur_pair.newer;
      window[2][2] <= s1_pix;
    end
  end

  // Control lines up with the window it belongs to.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ctl <= '0;
    end else if (s1_valid) begin
      window_ctl <= s1_ctl;
    end else begin
      window_ctl.emit <= 1'b0;
    end
  end

endmodule

/* hw/rtl/mbb_mean.sv */
// Masked neighborhood sum and reciprocal divide, four register stages.
module mbb_mean (
  input  logic                        clk,
  input  logic                        rst,
  input  mbb_pkg::pixel_t [2:0][2:0]  window,
  input  mbb_pkg::emit_ctl_t          window_ctl,
  output logic                        res_valid,
  output mbb_pkg::out_item_t          res
);

  localparam int ChanW = mbb_pkg::ChanW;

  logic [2:0][2:0][mbb_pkg::RowSumW-1:0] row_sum;

  logic                                  s2_valid;
  logic [2:0][2:0][mbb_pkg::RowSumW-1:0] s2_row_sum;
  mbb_pkg::pixel_t                       s2_center;
  logic [3:0]                            s2_count;
  logic                                  s2_last;

  logic                                  s3_valid;
  logic [2:0][mbb_pkg::SumW-1:0]         s3_total;
  logic [mbb_pkg::RecipW-1:0]            s3_recip;
  mbb_pkg::pixel_t                       s3_center;
  logic                                  s3_last;

  logic                                  s4_valid;
  logic [2:0][mbb_pkg::ProdW-1:0]        s4_prod;
  mbb_pkg::pixel_t                       s4_center;
  logic                                  s4_last;

  logic [2:0][ChanW-1:0]                 mean_chan;

  // Per-row sums of the taps inside the image.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < 3; ch++) begin
        row_sum[r][ch] = '0;
        for (int c = 0; c < 3; c++) begin
          if (window_ctl.tap_mask[r*3 + c]) begin
            row_sum[r][ch] = row_sum[r][ch] + mbb_pkg::RowSumW'(window[r][c].chan[ch]);
          end
        end
      end
    end
  end

  // Valid chain through the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s2_valid  <= window_ctl.emit;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
    end
  end

  // Row sums, then the total and the divisor reciprocal, then the product.
  always_ff @(posedge clk) begin
    s2_row_sum <= row_sum;
    s2_center  <= window[1][1];
    s2_count   <= window_ctl.count;
    s2_last    <= window_ctl.last;

    for (int ch = 0; ch < 3; ch++) begin
      s3_total[ch] <= mbb_pkg::SumW'(s2_row_sum[0][ch])
                    + mbb_pkg::SumW'(s2_row_sum[1][ch])
                    + mbb_pkg::SumW'(s2_row_sum[2][ch]);
    end
    s3_recip  <= mbb_pkg::recip(s2_count);
    s3_center <= s2_center;
    s3_last   <= s2_last;

    for (int ch = 0; ch < 3; ch++) begin
      s4_prod[ch] <= mbb_pkg::ProdW'(s3_total[ch]) * mbb_pkg::ProdW'(s3_recip);
    end
    s4_center <= s3_center;
    s4_last   <= s3_last;
  end

  // A kept center pixel passes through; otherwise take the scaled quotient.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_chan[ch] = s4_center.keep ? s4_center.chan[ch]
                                     : s4_prod[ch][mbb_pkg::RecipShift +: ChanW];
    end
  end

  always_ff @(posedge clk) begin
    res.out_red    <= mean_chan[0];
    res.out_green  <= mean_chan[1];
    res.out_blue   <= mean_chan[2];
    res.last_pixel <= s4_last;
  end

endmodule

/* hw/rtl/masked_box_blur_3x3.sv */
// Top level of the masked 3x3 box blur: position control, result queue.
//
// Channel  Handshake             Payload
// pix      pix_valid, pix_stall  mbb_pkg::in_item_t, one pixel or drain tick
// res      res_valid, res_stall  mbb_pkg::out_item_t, one result pixel
// cfg      cfg_valid, cfg_ready  image side, 11 bits
//
// One item is accepted per clock while pix_stall is low; the result of an
// item completing its neighborhood passes the line window and mean pipeline
// into the queue; res_valid rises in the next cycle. The line memory is read
// at acceptance and written back in the next cycle, when a same-column read
// is forwarded. Reset clears counters, the window and the queue, not the line
// memory. pix_stall rises only when eight results are in flight or queued.
`include "masked_box_blur_3x3_assert.svh"

module masked_box_blur_3x3 #(
  parameter int MAX_SIDE = mbb_pkg::MaxSideDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  mbb_pkg::in_item_t          pix_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output mbb_pkg::out_item_t         res_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mbb_pkg::SideW-1:0]  cfg_data
);

  localparam int PosW     = $clog2(MAX_SIDE);
  localparam int SideLW   = $clog2(MAX_SIDE + 1);
  localparam int CntW     = $clog2(MAX_SIDE + 2);
  localparam int QDepth   = mbb_pkg::QueueDepth;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int CredW    = $clog2(QDepth + 1);
  localparam int SideInit = (mbb_pkg::SideReset > MAX_SIDE) ? MAX_SIDE : mbb_pkg::SideReset;

  logic                cfg_write;
  logic [SideLW-1:0]   side;
  logic [SideLW-1:0]   side_clip;
  logic [PosW-1:0]     side_m1;

  logic [PosW-1:0]     in_row, in_row_next, in_col, in_col_next;
  logic [PosW-1:0]     out_row, out_row_next, out_col, out_col_next;
  logic [PosW-1:0]     in_row_adv, in_col_adv, out_row_adv, out_col_adv;
  logic [CntW-1:0]     fill, fill_next, pend, pend_next;

  logic                accept, is_drain, enter, full;
  mbb_pkg::pixel_t     enter_pix;
  mbb_pkg::emit_ctl_t  enter_ctl;
  logic                at_top, at_bottom, at_left, at_right;
  logic [1:0]          rows_in, cols_in;

  mbb_pkg::pixel_t [2:0][2:0] window;
  mbb_pkg::emit_ctl_t         window_ctl;
  logic                       mean_valid;
  mbb_pkg::out_item_t         mean_res;

  logic [CredW-1:0]    credit, credit_next;
  logic                res_xfer;
  mbb_pkg::out_item_t  queue [QDepth];
  logic [QPtrW-1:0]    q_head, q_tail;
  logic [CredW-1:0]    q_count;

  // Configuration: always ready, side clipped into the supported range.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      side_clip = SideLW'(1);
    end else if (32'(cfg_data) > MAX_SIDE) begin
      side_clip = SideLW'(MAX_SIDE);
    end else begin
      side_clip = SideLW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SideLW'(SideInit);
    end else if (cfg_write) begin
      side <= side_clip;
    end
  end

  assign side_m1 = PosW'(side - SideLW'(1));

  // Input acceptance; an idle drain tick is taken and dropped.
  assign pix_stall = (credit == CredW'(QDepth));
  assign accept    = pix_valid && !pix_stall;
  assign is_drain  = (pix_data.command == mbb_pkg::CMD_DRAIN);
  assign enter     = accept && !(is_drain && pend == '0);
  assign full      = (fill > CntW'(side));

  // Raster advance of both positions.
  always_comb begin
    in_col_adv  = (in_col == side_m1) ? '0 : in_col + PosW'(1);
    in_row_adv  = in_row;
    if (in_col == side_m1) begin
      in_row_adv = (in_row == side_m1) ? '0 : in_row + PosW'(1);
    end
    out_col_adv = (out_col == side_m1) ? '0 : out_col + PosW'(1);
    out_row_adv = out_row;
    if (out_col == side_m1) begin
      out_row_adv = (out_row == side_m1) ? '0 : out_row + PosW'(1);
    end
  end

  // Position, fill and pending counts.
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    fill_next    = fill;
    pend_next    = pend;
    if (enter) begin
      in_row_next = in_row_adv;
      in_col_next = in_col_adv;
      if (!full) begin
        fill_next = fill + CntW'(1);
        if (!is_drain) begin
          pend_next = pend + CntW'(1);
        end
      end else begin
        out_row_next = out_row_adv;
        out_col_next = out_col_adv;
        if (is_drain) begin
          pend_next = pend - CntW'(1);
          // Last pending pixel answered: realign input to output.
          if (pend == CntW'(1)) begin
            in_row_next = out_row_adv;
            in_col_next = out_col_adv;
            fill_next   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      fill    <= '0;
      pend    <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      fill    <= fill_next;
      pend    <= pend_next;
    end
  end

  // Pixel entering the window; a drain tick enters a kept zero pixel.
  always_comb begin
    enter_pix.keep = is_drain ? 1'b1 : pix_data.keep;
    enter_pix.chan = is_drain ? '0
                              : {pix_data.in_blue, pix_data.in_green, pix_data.in_red};
  end

  // Border clipping of the neighborhood around the output position.
  assign at_top    = (out_row == '0);
  assign at_bottom = (out_row == side_m1);
  assign at_left   = (out_col == '0);
  assign at_right  = (out_col == side_m1);
  assign rows_in   = 2'd1 + 2'(!at_top) + 2'(!at_bottom);
  assign cols_in   = 2'd1 + 2'(!at_left) + 2'(!at_right);

  always_comb begin
    enter_ctl.emit  = full;
    enter_ctl.last  = at_bottom && at_right;
    enter_ctl.count = 4'(rows_in) * 4'(cols_in);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        enter_ctl.tap_mask[r*3 + c] = !((r == 0 && at_top) || (r == 2 && at_bottom) ||
                                        (c == 0 && at_left) || (c == 2 && at_right));
      end
    end
  end

  mbb_line_window #(
    .MAX_SIDE (MAX_SIDE)
  ) u_line_window (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .enter      (enter),
    .enter_col  (in_col),
    .enter_pix  (enter_pix),
    .enter_ctl  (enter_ctl),
    .window     (window),
    .window_ctl (window_ctl)
  );

  mbb_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .window     (window),
    .window_ctl (window_ctl),
    .res_valid  (mean_valid),
    .res        (mean_res)
  );

  // Credits cover every result in the pipeline or the queue.
  assign res_xfer = res_valid && !res_stall;

  always_comb begin
    credit_next = credit;
    if (enter && full && !res_xfer) begin
      credit_next = credit + CredW'(1);
    end else if (!(enter && full) && res_xfer) begin
      credit_next = credit - CredW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit_next;
    end
  end

  // Result queue between the pipeline and the output channel.
  always_ff @(posedge clk) begin
    if (mean_valid) begin
      queue[q_tail] <= mean_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (mean_valid) begin
        q_tail <= q_tail + QPtrW'(1);
      end
      if (res_xfer) begin
        q_head <= q_head + QPtrW'(1);
      end
      if (mean_valid && !res_xfer) begin
        q_count <= q_count + CredW'(1);
      end else if (!mean_valid && res_xfer) begin
        q_count <= q_count - CredW'(1);
      end
    end
  end

  assign res_valid = (q_count != '0);
  assign res_data  = queue[q_head];

  // Consistency checks on counters and queue occupancy.
  `MBB_ASSERT_NOW(a_credit_covers_queue, 1'b1, q_count <= credit, "queue holds uncredited results")
  `MBB_ASSERT_NOW(a_queue_room, mean_valid, q_count < CredW'(QDepth), "result arrives at a full queue")
  `MBB_ASSERT_NOW(a_pend_within_fill, 1'b1, pend <= fill, "pending pixels exceed window fill")
  `MBB_ASSERT_NEXT(a_drain_realign, enter && full && is_drain && pend == CntW'(1), fill == '0, "fill not cleared after last drain")

endmodule
